/* rtl/core/mccf_pkg.sv */
// shared types and constants of the motor command framer
package mccf_pkg;

    localparam int MAX_MOTORS = 8;
    localparam int COUNT_W    = 4;
    localparam int MOTOR_W    = 3;
    localparam int IDX_W      = (MAX_MOTORS > 1) ? $clog2(MAX_MOTORS) : 1;
    localparam int ID_W       = 11;
    localparam int QDEPTH     = 2;

    localparam logic [ID_W-1:0] ID_BASE = 11'h140;

    // input actions
    localparam logic [3:0] ACT_ON_ALL    = 4'd0;
    localparam logic [3:0] ACT_OFF_ALL   = 4'd1;
    localparam logic [3:0] ACT_STOP_ALL  = 4'd2;
    localparam logic [3:0] ACT_TORQUE    = 4'd3;
    localparam logic [3:0] ACT_SPEED     = 4'd4;
    localparam logic [3:0] ACT_ANGLE     = 4'd5;
    localparam logic [3:0] ACT_ANGLE_SPD = 4'd6;
    localparam logic [3:0] ACT_ABS       = 4'd7;
    localparam logic [3:0] ACT_ABS_SPD   = 4'd8;
    localparam logic [3:0] ACT_INC       = 4'd9;
    localparam logic [3:0] ACT_INC_SPD   = 4'd10;
    localparam logic [3:0] ACT_REQ_9A    = 4'd11;
    localparam logic [3:0] ACT_REQ_9C    = 4'd12;
    localparam logic [3:0] ACT_REQ_92    = 4'd13;
    localparam logic [3:0] ACT_REPLY     = 4'd14;

    // frame command codes
    localparam logic [7:0] CODE_ON        = 8'h88;
    localparam logic [7:0] CODE_OFF       = 8'h80;
    localparam logic [7:0] CODE_STOP      = 8'h81;
    localparam logic [7:0] CODE_TORQUE    = 8'hA1;
    localparam logic [7:0] CODE_SPEED     = 8'hA2;
    localparam logic [7:0] CODE_ANGLE     = 8'hA3;
    localparam logic [7:0] CODE_ANGLE_SPD = 8'hA4;
    localparam logic [7:0] CODE_ABS       = 8'hA5;
    localparam logic [7:0] CODE_ABS_SPD   = 8'hA6;
    localparam logic [7:0] CODE_INC       = 8'hA7;
    localparam logic [7:0] CODE_INC_SPD   = 8'hA8;
    localparam logic [7:0] CODE_REQ_9A    = 8'h9A;
    localparam logic [7:0] CODE_REQ_9C    = 8'h9C;
    localparam logic [7:0] CODE_REQ_92    = 8'h92;

    typedef enum logic [1:0] {
        MUL_ONE = 2'd0,
        MUL_100 = 2'd1,
        MUL_600 = 2'd2
    } mul_sel_t;

    // one queued command: a broadcast or a single frame
    typedef struct packed {
        logic               bcast;
        logic [COUNT_W-1:0] count;
        logic [MOTOR_W-1:0] motor;
        logic [7:0]         code;
        logic [7:0]         b1;
        logic [15:0]        w23;
        logic [31:0]        val;
        mul_sel_t           mul;
    } cmd_t;

endpackage

/* rtl/core/motor_can_command_framer_unit.sv */
// top level of the motor command framer
//
// input channel: an item (action plus its fields) is taken at a clock edge
// with push high and full low. replies, gated commands and unused actions
// are absorbed by the front end and leave no frame.
// config: bus_size_we writes bus_size_wdata; write only while idle.
// result channel: the oldest frame sits on frame_id / frame_payload /
// last_frame while empty is low, and leaves at an edge with pop high.
// a single-motor command passes through the queue, the back end's fetch
// and the output register before its frame shows. a broadcast gives one
// frame per cycle while the receiver takes them, one to eight frames, with
// last_frame on the final one. the back end fetches each queued command in
// its idle state and takes no new one until the last frame of the current
// command is loaded.
// a two-entry command queue decouples classification from framing.
// reset clears the queue and output, sets the motor count to one, clears the
// pending-request flag and opens the speed lock.
// when the receiver stalls, the output frame holds, the back end waits,
// and the input raises full once the queue has filled.
module motor_can_command_framer_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic [3:0]                   action,
    input  logic [mccf_pkg::MOTOR_W-1:0] motor_sel,
    input  logic signed [31:0]           target_value,
    input  logic [15:0]                  max_speed,
    input  logic [7:0]                   spin_direction,
    input  logic [10:0]                  reply_id,
    input  logic [7:0]                   reply_code,
    input  logic                         bus_size_we,
    input  logic [mccf_pkg::COUNT_W-1:0] bus_size_wdata,
    output logic                         empty,
    input  logic                         pop,
    output logic [mccf_pkg::ID_W-1:0]    frame_id,
    output logic [63:0]                  frame_payload,
    output logic                         last_frame
);
    import mccf_pkg::*;

    logic accept;
    logic q_push, q_pop, q_empty;
    cmd_t q_wr_cmd, q_rd_cmd;

    assign accept = push && !full;

    mccf_front u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .accept            (accept),
        .action            (action),
        .motor_sel         (motor_sel),
        .target_value      (target_value),
        .max_speed         (max_speed),
        .spin_direction    (spin_direction),
        .reply_id          (reply_id),
        .reply_code        (reply_code),
        .bus_size_we       (bus_size_we),
        .bus_size_wdata    (bus_size_wdata),
        .q_push            (q_push),
        .q_cmd             (q_wr_cmd)
    );

    mccf_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (q_push),
        .wr_cmd (q_wr_cmd),
        .rd_en  (q_pop),
        .rd_cmd (q_rd_cmd),
        .full   (full),
        .empty  (q_empty)
    );

    mccf_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_cmd         (q_rd_cmd),
        .q_pop         (q_pop),
        .pop           (pop),
        .empty         (empty),
        .frame_id      (frame_id),
        .frame_payload (frame_payload),
        .last_frame    (last_frame)
    );

endmodule

/* rtl/core/mccf_front.sv */
// front end: config register, send-gating flags and command classification
module mccf_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  logic [3:0]                  action,
    input  logic [mccf_pkg::MOTOR_W-1:0] motor_sel,
    input  logic signed [31:0]          target_value,
    input  logic [15:0]                 max_speed,
    input  logic [7:0]                  spin_direction,
    input  logic [10:0]                 reply_id,
    input  logic [7:0]                  reply_code,
    input  logic                        bus_size_we,
    input  logic [mccf_pkg::COUNT_W-1:0] bus_size_wdata,
    output logic                        q_push,
    output mccf_pkg::cmd_t              q_cmd
);
    import mccf_pkg::*;

    logic [COUNT_W-1:0] bus_size_reg;
    logic               pending_reg, pending_next;
    logic               lock_clear_reg, lock_clear_next;
    logic [COUNT_W-1:0] n_eff;
    logic               emit;
    logic               reply_hit;
    cmd_t               cmd;

    function automatic logic [31:0] clamp_s(input logic signed [31:0] v,
                                            input logic signed [31:0] lim);
        logic [31:0] r;
        if (v > lim)
            r = lim;
        else if (v < -lim)
            r = -lim;
        else
            r = v;
        return r;
    endfunction

    function automatic logic [15:0] spd_limit(input logic [15:0] ms,
                                              input logic [15:0] lim);
        logic [15:0] s;
        s = (ms > lim) ? lim : ms;
        return 16'(s * 16'd6);
    endfunction

    assign n_eff = (bus_size_reg > COUNT_W'(MAX_MOTORS)) ? COUNT_W'(MAX_MOTORS)
                                                         : bus_size_reg;
    assign reply_hit = (reply_id >= ID_BASE + 11'd1) &&
                       (reply_id <= ID_BASE + ID_W'(n_eff));

    always_comb
    begin
        emit            = 1'b0;
        pending_next    = pending_reg;
        lock_clear_next = lock_clear_reg;
        cmd.bcast       = 1'b0;
        cmd.count       = n_eff;
        cmd.motor       = motor_sel;
        cmd.code        = CODE_TORQUE;
        cmd.b1          = 8'd0;
        cmd.w23         = 16'd0;
        cmd.val         = 32'd0;
        cmd.mul         = MUL_ONE;
        unique case (action)
            ACT_ON_ALL, ACT_OFF_ALL, ACT_STOP_ALL:
            begin
                emit      = (n_eff != '0);
                cmd.bcast = 1'b1;
                cmd.code  = (action == ACT_ON_ALL)  ? CODE_ON  :
                            (action == ACT_OFF_ALL) ? CODE_OFF : CODE_STOP;
            end
            ACT_REQ_9A, ACT_REQ_9C, ACT_REQ_92:
            begin
                emit         = 1'b1;
                pending_next = 1'b1;
                cmd.code     = (action == ACT_REQ_9A) ? CODE_REQ_9A :
                               (action == ACT_REQ_9C) ? CODE_REQ_9C : CODE_REQ_92;
            end
            ACT_REPLY:
            begin
                if (reply_hit)
                begin
                    if (reply_code == CODE_REQ_9C || reply_code == CODE_REQ_9A ||
                        reply_code == CODE_REQ_92)
                    begin
                        pending_next    = 1'b0;
                        lock_clear_next = 1'b1;
                    end
                    else if (reply_code == CODE_SPEED)
                        lock_clear_next = 1'b0;
                end
            end
            ACT_TORQUE:
            begin
                emit     = !pending_reg;
                cmd.code = CODE_TORQUE;
                cmd.val  = {16'd0, 16'(clamp_s(target_value, 32'sd2048))};
            end
            ACT_SPEED:
            begin
                emit     = !pending_reg && lock_clear_reg;
                cmd.code = CODE_SPEED;
                cmd.val  = clamp_s(target_value, 32'sd1900);
                cmd.mul  = MUL_600;
            end
            ACT_ANGLE, ACT_ANGLE_SPD:
            begin
                emit     = !pending_reg;
                cmd.code = (action == ACT_ANGLE) ? CODE_ANGLE : CODE_ANGLE_SPD;
                cmd.val  = clamp_s(target_value, 32'sd21474836);
                cmd.mul  = MUL_100;
                if (action == ACT_ANGLE_SPD)
                    cmd.w23 = spd_limit(max_speed, 16'd1500);
            end
            ACT_ABS, ACT_ABS_SPD:
            begin
                emit     = !pending_reg;
                cmd.code = (action == ACT_ABS) ? CODE_ABS : CODE_ABS_SPD;
                cmd.b1   = spin_direction;
                cmd.val  = target_value;
                cmd.mul  = MUL_100;
                if (action == ACT_ABS_SPD)
                    cmd.w23 = spd_limit(max_speed, 16'd1500);
            end
            ACT_INC, ACT_INC_SPD:
            begin
                emit     = !pending_reg;
                cmd.code = (action == ACT_INC) ? CODE_INC : CODE_INC_SPD;
                cmd.val  = target_value;
                cmd.mul  = MUL_100;
                if (action == ACT_INC_SPD)
                    cmd.w23 = spd_limit(max_speed, 16'd1900);
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
        // every emitted frame reopens the speed lock unless it is a speed frame
        if (emit)
            lock_clear_next = (cmd.code != CODE_SPEED);
    end

    assign q_push = accept && emit;
    assign q_cmd  = cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bus_size_reg   <= COUNT_W'(1);
            pending_reg    <= 1'b0;
            lock_clear_reg <= 1'b1;
        end
        else
        begin
            if (bus_size_we)
                bus_size_reg <= bus_size_wdata;
            if (accept)
            begin
                pending_reg    <= pending_next;
                lock_clear_reg <= lock_clear_next;
            end
        end
    end

endmodule

/* rtl/core/mccf_queue.sv */
// short command queue between front and back end
module mccf_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  mccf_pkg::cmd_t wr_cmd,
    input  logic           rd_en,
    output mccf_pkg::cmd_t rd_cmd,
    output logic           full,
    output logic           empty
);
    import mccf_pkg::*;

    localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CNT_W = $clog2(QDEPTH + 1);

    cmd_t             slot_reg [QDEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_wr, do_rd;

    assign full   = (cnt_reg == CNT_W'(QDEPTH));
    assign empty  = (cnt_reg == '0);
    assign do_wr  = wr_en && !full;
    assign do_rd  = rd_en && !empty;
    assign rd_cmd = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_wr && !do_rd)
            cnt_next = cnt_reg + CNT_W'(1);
        else if (do_rd && !do_wr)
            cnt_next = cnt_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wr_ptr_reg] <= wr_cmd;
    end

endmodule

/* rtl/core/mccf_back.sv */
// back end: frame sequencer with scaling multiply and output register
module mccf_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       q_empty,
    input  mccf_pkg::cmd_t             q_cmd,
    output logic                       q_pop,
    input  logic                       pop,
    output logic                       empty,
    output logic [mccf_pkg::ID_W-1:0]  frame_id,
    output logic [63:0]                frame_payload,
    output logic                       last_frame
);
    import mccf_pkg::*;

    typedef enum logic [1:0] {
        BK_IDLE = 2'b01,
        BK_EMIT = 2'b10
    } back_state_t;

    back_state_t       state_reg, state_next;
    cmd_t              cur_reg;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              out_valid_reg, out_valid_next;
    logic [ID_W-1:0]   id_reg;
    logic [63:0]       payload_reg;
    logic              last_reg;
    logic              out_load;
    logic              is_last;
    logic [31:0]       w47;
    logic [ID_W-1:0]   id_calc;

    assign out_load = (state_reg == BK_EMIT) && (!out_valid_reg || pop);
    assign is_last  = cur_reg.bcast ? (COUNT_W'(idx_reg) + COUNT_W'(1) == cur_reg.count)
                                    : 1'b1;
    assign id_calc  = cur_reg.bcast ? ID_BASE + ID_W'(idx_reg) + ID_W'(1)
                                    : ID_BASE + ID_W'(cur_reg.motor) + ID_W'(1);

    always_comb
    begin
        unique case (cur_reg.mul)
            MUL_100: w47 = 32'(cur_reg.val * 32'd100);
            MUL_600: w47 = 32'(cur_reg.val * 32'd600);
            default: w47 = cur_reg.val;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        q_pop      = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    idx_next   = '0;
                    state_next = BK_EMIT;
                end
            end
            BK_EMIT:
            begin
                if (out_load)
                begin
                    idx_next = idx_reg + IDX_W'(1);
                    if (is_last)
                        state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
        if (out_load)
            out_valid_next = 1'b1;
        else if (pop)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            cur_reg <= q_cmd;
        if (out_load)
        begin
            id_reg      <= id_calc;
            payload_reg <= {w47, cur_reg.w23, cur_reg.b1, cur_reg.code};
            last_reg    <= is_last;
        end
    end

    assign empty         = !out_valid_reg;
    assign frame_id      = id_reg;
    assign frame_payload = payload_reg;
    assign last_frame    = last_reg;

endmodule

/* rtl/core/mccf_checker.sv */
// port-level checks of the motor command framer and their bind
module mccf_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      empty,
    input logic                      pop,
    input logic [mccf_pkg::ID_W-1:0] frame_id,
    input logic [63:0]               frame_payload,
    input logic                      last_frame
);
    import mccf_pkg::*;

    // a waiting frame holds while not taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(frame_id) &&
                              $stable(frame_payload) && $stable(last_frame)))
        else $error("waiting frame changed");

    a_id_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (frame_id >= ID_BASE + ID_W'(1) &&
                    frame_id <= ID_BASE + ID_W'(MAX_MOTORS)))
        else $error("frame id out of motor range");

    // inside a broadcast the next motor's frame follows at once
    a_bcast_next: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && !last_frame) |=>
            (!empty && frame_id == $past(frame_id) + ID_W'(1) &&
             frame_payload[7:0] == $past(frame_payload[7:0])))
        else $error("broadcast sequence broken");

    a_bcast_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (frame_payload[7:0] == CODE_ON || frame_payload[7:0] == CODE_OFF ||
                    frame_payload[7:0] == CODE_STOP)) |-> (frame_payload[63:8] == '0))
        else $error("broadcast frame carries data");

    a_torque_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && frame_payload[7:0] == CODE_TORQUE) |->
            (frame_payload[31:8] == '0 && frame_payload[63:48] == '0 && last_frame))
        else $error("torque frame layout wrong");

endmodule

bind motor_can_command_framer_unit mccf_checker u_mccf_checker (.*);
